// File: hdl/epg_pkg.sv
// Shared types for the Euclidean pattern generator: item structs, controller states, commands, status.
package epg_pkg;

  localparam int unsigned WORD_BITS = 64;

  typedef struct packed {
    logic [6:0] pattern_length;
    logic [6:0] pulse_count;
    logic [5:0] rotation;
  } epg_in_t;

  typedef struct packed {
    logic [63:0] pattern_bits;
    logic        input_error;
  } epg_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_CONCAT,
    ST_ALIGN,
    ST_ROTATE,
    ST_DONE
  } epg_state_t;

  typedef struct packed {
    logic load;
    logic round;
    logic emit;
    logic align;
    logic rotate;
  } epg_cmd_t;

  typedef struct packed {
    logic err;
    logic round_done;
    logic cat_done;
  } epg_status_t;

endpackage

// File: hdl/euclidean_pattern_generator_core.sv
// Top level of the Euclidean pattern generator: controller plus datapath.
//
// Usage: drive item (pattern_length, pulse_count, rotation) and raise start
// while busy is low; the transfer happens at that clock edge. busy then stays
// high until the result has been presented. The result appears on result for
// exactly one cycle, marked by result_valid; the receiver cannot stall it and
// must take it in that cycle.
//
// Sequence: the controller runs the grouping rounds one at a time, then sees
// that the rounds are over, concatenates the groups one at a time, then sees
// that the concatenation is over, then does the alignment and the rotation.
// result_valid is high in the done state that follows the rotation. Every
// round merges at least one pair of groups, so rounds plus final groups
// never exceed pattern_length. One item is in flight at a time; a new
// transfer may start the cycle after result_valid. An invalid item (count
// zero or above the length, length out of range, rotation not below the
// length) skips the work: the controller goes from the round state straight
// to the done state, and result_valid comes with input_error set and a zero
// pattern.
//
// Reset (synchronous, active high) returns the controller to idle; no result
// is produced for an item whose work was cut short by reset.
module euclidean_pattern_generator_core #(
  parameter int unsigned MAX_STEPS = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  epg_pkg::epg_in_t  item,
  output logic              result_valid,
  output epg_pkg::epg_out_t result
);
  import epg_pkg::*;

  epg_cmd_t    cmd;
  epg_status_t status;

  // The controller only sees status from the datapath and only issues commands to it.
  epg_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .status       (status),
    .cmd          (cmd),
    .busy         (busy),
    .result_valid (result_valid)
  );

  epg_dp #(
    .MAX_STEPS (MAX_STEPS)
  ) u_dp (
    .clk    (clk),
    .item   (item),
    .cmd    (cmd),
    .status (status),
    .result (result)
  );

  // A transfer always starts work.
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("transfer did not start work");

  // After a result the block is free again.
  a_result_free: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !busy)
    else $error("block still busy after result");

  // A result is a single-cycle strobe.
  a_one_cycle: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("result strobe longer than one cycle");

  // An error result carries no pattern.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.input_error) |-> (result.pattern_bits == 64'd0))
    else $error("error result with nonzero pattern");

endmodule

// File: hdl/epg_ctrl.sv
// Controller state machine that sequences the grouping rounds, concatenation and final shifts.
module epg_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  epg_pkg::epg_status_t status,
  output epg_pkg::epg_cmd_t   cmd,
  output logic                busy,
  output logic                result_valid
);
  import epg_pkg::*;

  epg_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next   = state;
    cmd          = '0;
    busy         = (state != ST_IDLE);
    result_valid = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_ROUND;
        end
      end
      ST_ROUND: begin
        // An invalid item skips all work; the datapath holds a zero pattern.
        if (status.err)             state_next = ST_DONE;
        else if (status.round_done) state_next = ST_CONCAT;
        else                        cmd.round  = 1'b1;
      end
      ST_CONCAT: begin
        if (status.cat_done) state_next = ST_ALIGN;
        else                 cmd.emit   = 1'b1;
      end
      ST_ALIGN: begin
        cmd.align  = 1'b1;
        state_next = ST_ROTATE;
      end
      ST_ROTATE: begin
        cmd.rotate = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        result_valid = 1'b1;
        state_next   = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// File: hdl/epg_dp.sv
// Datapath: group strings, group counts, the concatenation accumulator and the rotator.
module epg_dp #(
  parameter int unsigned MAX_STEPS = 64
) (
  input  logic                 clk,
  input  epg_pkg::epg_in_t     item,
  input  epg_pkg::epg_cmd_t    cmd,
  output epg_pkg::epg_status_t status,
  output epg_pkg::epg_out_t    result
);
  import epg_pkg::*;

  // Appends b (w bits wide) below a; a group of the full word width replaces a.
  function automatic logic [63:0] glue(input logic [63:0] a, input logic [63:0] b,
                                       input logic [6:0] w);
    logic [63:0] r;
    if (w[6]) r = b;
    else      r = (a << w[5:0]) | b;
    return r;
  endfunction

  logic [63:0] a_bits, b_bits, acc;
  logic [6:0]  a_w, b_w, n_on, n_off, len;
  logic [5:0]  rot;
  logic        err;
  logic [6:0]  pairs;
  logic        bad;
  logic [5:0]  lsh;
  logic [63:0] mask;

  assign bad = (item.pattern_length == 7'd0) ||
               (item.pattern_length > 7'(MAX_STEPS)) ||
               (item.pulse_count == 7'd0) ||
               (item.pulse_count > item.pattern_length) ||
               ({1'b0, item.rotation} >= item.pattern_length);

  assign pairs = (n_on < n_off) ? n_on : n_off;
  assign lsh   = 6'(len - {1'b0, rot});
  assign mask  = ~(64'(~64'd0 >> len[5:0])) | {64{len[6]}};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      len    <= item.pattern_length;
      rot    <= item.rotation;
      err    <= bad;
      a_bits <= 64'd1;
      a_w    <= 7'd1;
      b_bits <= 64'd0;
      b_w    <= 7'd1;
      n_on   <= item.pulse_count;
      n_off  <= item.pattern_length - item.pulse_count;
      acc    <= 64'd0;
    end else if (cmd.round) begin
      // All on groups are alike and all off groups are alike, so one pair
      // of strings and two counts carry the whole grouping state.
      a_bits <= glue(a_bits, b_bits, b_w);
      a_w    <= a_w + b_w;
      if (n_on > n_off) begin
        b_bits <= a_bits;
        b_w    <= a_w;
        n_off  <= n_on - pairs;
      end else if (n_on < n_off) begin
        n_off  <= n_off - pairs;
      end else begin
        n_off  <= 7'd0;
      end
      n_on <= pairs;
    end else if (cmd.emit) begin
      if (n_on != 7'd0) begin
        acc  <= glue(acc, a_bits, a_w);
        n_on <= n_on - 7'd1;
      end else begin
        acc   <= glue(acc, b_bits, b_w);
        n_off <= n_off - 7'd1;
      end
    end else if (cmd.align) begin
      acc <= acc << 6'(7'd64 - len);
    end else if (cmd.rotate) begin
      if (rot != 6'd0) acc <= ((acc >> rot) | (acc << lsh)) & mask;
      else             acc <= acc & mask;
    end
  end

  assign status.err        = err;
  assign status.round_done = (n_off <= 7'd1) || (n_on == 7'd0);
  assign status.cat_done   = (n_on == 7'd0) && (n_off == 7'd0);

  assign result.pattern_bits = err ? 64'd0 : acc;
  assign result.input_error  = err;

endmodule
